// ----- hdl/tsm_pkg.sv -----
// Shared types and constants for the timestamp merge of hit sources.
`default_nettype none

package tsm_pkg;

  localparam int SOURCES_DEF = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [4:0] CPB_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_PER_BOARD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SOURCES     = 1'd1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_END  = 2'd1,
    OP_PULL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_HIT       = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  source;
    logic [63:0] hit_time;
    logic [15:0] long_gate;
    logic [15:0] short_gate;
    logic [3:0]  board_number;
    logic [3:0]  channel_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_time;
    logic [15:0] out_long;
    logic [15:0] out_short;
    logic [7:0]  channel_id;
  } out_item_t;

  // One stored head hit.
  typedef struct packed {
    logic [63:0] hit_time;
    logic [15:0] long_gate;
    logic [15:0] short_gate;
    logic [3:0]  board_number;
    logic [3:0]  channel_number;
  } head_rec_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic emit;
  } tsm_cmd_t;

  typedef struct packed {
    logic is_pull;
    logic need_scan;
    logic scan_last;
    logic out_free;
  } tsm_sts_t;

endpackage

`default_nettype wire

// ----- hdl/timestamp_merge_of_hit_sources.sv -----
// Top level of the timestamp merge of hit sources.
//
//   port group  direction  handshake         payload
//   in_         input      in_valid/in_stall in_data   (tsm_pkg::in_item_t)
//   out_        output     out_valid/out_stall out_data (tsm_pkg::out_item_t)
//   cfg_        input      cfg_we            cfg_index, cfg_data
//
// One item at a time. Load, end and unused codes are captured and executed; a
// pull whose status is known from the flags then emits; one that searches first
// scans one entry per cycle over the head store's single read port. Reset (rst_n
// low, synchronous) clears all flags and the run state and loads the config reset
// values; data registers are not reset. A stalled result beat stays in the output
// register while the next item is taken; only a following result waits for it.
`default_nettype none

module timestamp_merge_of_hit_sources #(
  parameter int SOURCES = tsm_pkg::SOURCES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tsm_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tsm_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [tsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  tsm_pkg::tsm_cmd_t cmd;
  tsm_pkg::tsm_sts_t sts;

  tsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsm_datapath #(
    .SOURCES (SOURCES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/tsm_ctrl.sv -----
// Controller state machine sequencing each item through the datapath.
`default_nettype none

module tsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tsm_pkg::tsm_sts_t sts,
  output tsm_pkg::tsm_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.is_pull) begin
          state_nxt = S_IDLE;
        end else if (sts.need_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tsm_datapath.sv -----
// Head store, source flags, sequential minimum search and result register.
`default_nettype none

module tsm_datapath #(
  parameter int SOURCES = tsm_pkg::SOURCES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tsm_pkg::in_item_t               in_data,
  input  wire logic                            cfg_we,
  input  wire logic [tsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire tsm_pkg::tsm_cmd_t               cmd,
  output tsm_pkg::tsm_sts_t                    sts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tsm_pkg::out_item_t                   out_data
);

  localparam int SRC_W = $clog2(SOURCES);
  localparam int CW    = $clog2(SOURCES + 1);
  localparam int UW    = (CW > 5) ? CW : 5;

  tsm_pkg::head_rec_t mem [SOURCES];

  tsm_pkg::in_item_t  item_r;
  logic [4:0]         cpb_r;
  logic [4:0]         active_r;
  logic [SOURCES-1:0] present_r, present_nxt;
  logic [SOURCES-1:0] ended_r, ended_nxt;
  logic               invalid_r, invalid_nxt;
  logic [1:0]         status_r, status_nxt;

  logic [CW-1:0]      cnt_r;
  tsm_pkg::head_rec_t rd_data_r;
  logic [SRC_W-1:0]   rd_idx_r;
  logic               rd_vld_r;
  tsm_pkg::head_rec_t best_r;
  logic [SRC_W-1:0]   best_idx_r;
  logic               found_r;

  logic               out_valid_r;
  tsm_pkg::out_item_t out_data_r;

  logic [UW-1:0]      used;
  logic [SOURCES-1:0] live;
  logic               src_in_use;
  logic [SRC_W-1:0]   src_addr;
  logic               mem_we;
  logic               out_free;
  logic               take;
  logic [8:0]         id_sum;
  tsm_pkg::head_rec_t load_rec;

  // Sources at or above the configured count, or the store size, are unused.
  always_comb begin
    used = (UW'(active_r) > UW'(SOURCES)) ? UW'(SOURCES) : UW'(active_r);
    for (int i = 0; i < SOURCES; i++) begin
      live[i] = (UW'(i) < used) && !ended_r[i];
    end
  end

  assign src_in_use = UW'(item_r.source) < used;
  assign src_addr   = SRC_W'(item_r.source);
  assign mem_we     = cmd.exec && (item_r.operation == tsm_pkg::OP_LOAD) && src_in_use
                      && !ended_r[src_addr];
  assign out_free   = !out_valid_r || !out_stall;
  assign take       = cmd.emit && out_free;

  assign load_rec = '{hit_time:       item_r.hit_time,
                      long_gate:      item_r.long_gate,
                      short_gate:     item_r.short_gate,
                      board_number:   item_r.board_number,
                      channel_number: item_r.channel_number};

  always_comb begin
    sts.is_pull   = item_r.operation == tsm_pkg::OP_PULL;
    sts.need_scan = !invalid_r && (used != '0) && (live != '0) && ((live & ~present_r) == '0);
    sts.scan_last = cnt_r == CW'(SOURCES);
    sts.out_free  = out_free;
  end

  always_comb begin
    present_nxt = present_r;
    ended_nxt   = ended_r;
    invalid_nxt = invalid_r;
    status_nxt  = status_r;
    if (cmd.exec) begin
      priority case (item_r.operation)
        tsm_pkg::OP_LOAD: begin
          if (mem_we) begin
            present_nxt[src_addr] = 1'b1;
          end
        end
        tsm_pkg::OP_END: begin
          if (src_in_use) begin
            ended_nxt[src_addr]   = 1'b1;
            present_nxt[src_addr] = 1'b0;
          end
        end
        tsm_pkg::OP_PULL: begin
          priority if (invalid_r) begin
            status_nxt = tsm_pkg::ST_INVALID;
          end else if (used == '0) begin
            invalid_nxt = 1'b1;
            status_nxt  = tsm_pkg::ST_INVALID;
          end else if (live == '0) begin
            invalid_nxt = 1'b1;
            status_nxt  = tsm_pkg::ST_EXHAUSTED;
          end else if ((live & ~present_r) != '0) begin
            status_nxt = tsm_pkg::ST_NOT_READY;
          end else begin
            status_nxt = tsm_pkg::ST_HIT;
          end
        end
        default: begin
        end
      endcase
    end
    // The winning head is freed when its result beat is loaded.
    if (take && (status_r == tsm_pkg::ST_HIT)) begin
      present_nxt[best_idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r       <= tsm_pkg::CPB_RESET;
      active_r    <= '0;
      present_r   <= '0;
      ended_r     <= '0;
      invalid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == tsm_pkg::CFG_CHANNELS_PER_BOARD)) begin
        cpb_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == tsm_pkg::CFG_ACTIVE_SOURCES)) begin
        active_r <= cfg_data;
      end
      present_r <= present_nxt;
      ended_r   <= ended_nxt;
      invalid_r <= invalid_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    status_r <= status_nxt;
  end

  // Head store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[src_addr] <= load_rec;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[cnt_r[SRC_W-1:0]];
  end

  // Scan: entry cnt is read while the entry read at the previous step is compared.
  // A strict less-than keeps the lower index on a tie.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      cnt_r    <= cnt_r + CW'(1);
      rd_idx_r <= cnt_r[SRC_W-1:0];
      rd_vld_r <= cnt_r != CW'(SOURCES);
      if (rd_vld_r && live[rd_idx_r]
          && (!found_r || (rd_data_r.hit_time < best_r.hit_time))) begin
        best_r     <= rd_data_r;
        best_idx_r <= rd_idx_r;
        found_r    <= 1'b1;
      end
    end
  end

  assign id_sum = 9'(best_r.board_number) * 9'(cpb_r) + 9'(best_r.channel_number);

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.status <= status_r;
      if (status_r == tsm_pkg::ST_HIT) begin
        out_data_r.out_time   <= best_r.hit_time;
        out_data_r.out_long   <= best_r.long_gate;
        out_data_r.out_short  <= best_r.short_gate;
        out_data_r.channel_id <= id_sum[7:0];
      end else begin
        out_data_r.out_time   <= '0;
        out_data_r.out_long   <= '0;
        out_data_r.out_short  <= '0;
        out_data_r.channel_id <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
